// ===== src/bls_pkg.sv =====
// shared types and constants for the bresenham line stepper
package bls_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // one classified item as it waits in the queue
  typedef struct packed {
    op_e    op;
    coord_t start_x;
    coord_t start_y;
    coord_t major_end;
    coord_t delta_major;
    coord_t delta_minor;
    logic   minor_neg;
    logic   steep;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic active;
    logic pop;
    logic emit;
    logic emit_last;
  } back_status_t;

endpackage

// ===== src/bls_front.sv =====
// front end: classifies a beat and works out the line setup for loads
module bls_front import bls_pkg::*; (
  input  logic   cmd_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  output entry_t entry_o
);

  logic signed [DIFF_BITS-1:0] dx, dy;
  coord_t adx, ady;
  logic   steep, swap;
  logic   dx_pos, dy_pos;

  always_comb begin
    dx     = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dy     = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    adx    = dx[DIFF_BITS-1] ? coord_t'(-dx) : coord_t'(dx);
    ady    = dy[DIFF_BITS-1] ? coord_t'(-dy) : coord_t'(dy);
    dx_pos = !dx[DIFF_BITS-1] && (dx != '0);
    dy_pos = !dy[DIFF_BITS-1] && (dy != '0);
    // equal magnitudes go steep
    steep  = !(ady < adx);
    swap   = steep ? dy[DIFF_BITS-1] : dx[DIFF_BITS-1];

    entry_o.op          = op_e'(cmd_i);
    entry_o.steep       = steep;
    entry_o.start_x     = swap ? end_x_i : start_x_i;
    entry_o.start_y     = swap ? end_y_i : start_y_i;
    entry_o.delta_major = steep ? ady : adx;
    entry_o.delta_minor = steep ? adx : ady;
    if (steep) begin
      entry_o.major_end = swap ? start_y_i : end_y_i;
      entry_o.minor_neg = swap ? dx_pos : dx[DIFF_BITS-1];
    end else begin
      entry_o.major_end = swap ? start_x_i : end_x_i;
      entry_o.minor_neg = swap ? dy_pos : dy[DIFF_BITS-1];
    end
  end

endmodule

// ===== src/bls_queue.sv =====
// short fifo between front and back
module bls_queue import bls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    push_data_i,
  input  logic      pop_i,
  output entry_t    head_o,
  output q_status_t status_o
);

  entry_t                mem_q [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]  cnt_q, cnt_d;
  logic                  do_push, do_pop;

  always_comb begin
    do_push = push_i && (cnt_q != QCNT_BITS'(QDEPTH));
    do_pop  = pop_i && (cnt_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == QCNT_BITS'(QDEPTH));

endmodule

// ===== src/bls_back.sv =====
// back end: line state, error term update and the output register
module bls_back import bls_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  entry_t       head_i,
  input  logic         head_valid_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output coord_t       pixel_x_o,
  output coord_t       pixel_y_o,
  output logic         last_o,
  output back_status_t status_o
);

  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t major_end_q, major_end_d;
  logic signed [ERR_BITS-1:0] err_q, err_d, inc_up_q, inc_up_d, inc_dn_q, inc_dn_d;
  logic minor_neg_q, minor_neg_d, steep_q, steep_d, active_q, active_d;
  logic out_valid_q, out_valid_d;
  coord_t pix_x_q, pix_y_q;
  logic   last_q;

  logic   out_free, pop, emit, err_pos, is_last;
  coord_t major, minor, major_nxt, minor_nxt;

  always_comb begin
    out_free  = !out_valid_q || !out_stall_i;
    pop       = head_valid_i && ((head_i.op == OP_LOAD) || !active_q || out_free);
    emit      = pop && (head_i.op == OP_STEP) && active_q;

    major     = steep_q ? cur_y_q : cur_x_q;
    minor     = steep_q ? cur_x_q : cur_y_q;
    major_nxt = major + 1'b1;
    is_last   = (major_nxt == major_end_q);
    err_pos   = !err_q[ERR_BITS-1] && (err_q != '0);
    if (err_pos) begin
      minor_nxt = minor_neg_q ? minor - 1'b1 : minor + 1'b1;
    end else begin
      minor_nxt = minor;
    end

    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    major_end_d = major_end_q;
    err_d       = err_q;
    inc_up_d    = inc_up_q;
    inc_dn_d    = inc_dn_q;
    minor_neg_d = minor_neg_q;
    steep_d     = steep_q;
    active_d    = active_q;

    if (pop) begin
      case (head_i.op)
        OP_LOAD: begin
          cur_x_d     = head_i.start_x;
          cur_y_d     = head_i.start_y;
          major_end_d = head_i.major_end;
          minor_neg_d = head_i.minor_neg;
          steep_d     = head_i.steep;
          active_d    = (head_i.delta_major != '0);
          err_d       = $signed({2'b00, head_i.delta_minor, 1'b0})
                      - $signed({3'b000, head_i.delta_major});
          inc_up_d    = $signed({2'b00, head_i.delta_minor, 1'b0});
          inc_dn_d    = $signed({2'b00, head_i.delta_minor, 1'b0})
                      - $signed({2'b00, head_i.delta_major, 1'b0});
        end
        OP_STEP: begin
          if (active_q) begin
            err_d    = err_q + (err_pos ? inc_dn_q : inc_up_q);
            cur_x_d  = steep_q ? minor_nxt : major_nxt;
            cur_y_d  = steep_q ? major_nxt : minor_nxt;
            active_d = !is_last;
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      major_end_q <= '0;
      err_q       <= '0;
      inc_up_q    <= '0;
      inc_dn_q    <= '0;
      minor_neg_q <= 1'b0;
      steep_q     <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      major_end_q <= major_end_d;
      err_q       <= err_d;
      inc_up_q    <= inc_up_d;
      inc_dn_q    <= inc_dn_d;
      minor_neg_q <= minor_neg_d;
      steep_q     <= steep_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_x_q <= cur_x_q;
      pix_y_q <= cur_y_q;
      last_q  <= is_last;
    end
  end

  assign pop_o              = pop;
  assign out_valid_o        = out_valid_q;
  assign pixel_x_o          = pix_x_q;
  assign pixel_y_o          = pix_y_q;
  assign last_o             = last_q;
  assign status_o.active    = active_q;
  assign status_o.pop       = pop;
  assign status_o.emit      = emit;
  assign status_o.emit_last = is_last;

endmodule

// ===== src/bresenham_line_stepper.sv =====
// top level of the bresenham line stepper: front, queue and back
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | cmd_i, start_x_i, start_y_i, end_x_i, end_y_i
//  out     | output    | out_valid_o/out_stall_i | pixel_x_o, pixel_y_o, last_o
//
// one beat per cycle in while the queue is not full and one pixel per cycle out while
// out_stall_i is low; a step beat behind an empty queue is written into the queue when
// it is taken and is then popped into the output register
// the rate is set by the back end's error term update, one add per pixel
// reset clears the queue, the line state (idle) and the output valid
// in_stall_o rises only when the two-entry queue is full; out_stall_i holds
// the pending pixel while loads and idle steps keep draining the queue
module bresenham_line_stepper import bls_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  logic   cmd_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output coord_t pixel_x_o,
  output coord_t pixel_y_o,
  output logic   last_o
);

  entry_t       front_entry;
  entry_t       head;
  q_status_t    q_st;
  back_status_t back_st;
  logic         pop;
  logic         push;

  // classify the beat and do the endpoint swap for loads
  bls_front u_front (
    .cmd_i     (cmd_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .entry_o   (front_entry)
  );

  // stall only on a full queue, so the input waits on the output side only once the queue fills
  assign in_stall_o = q_st.full;
  assign push       = in_valid_i && !q_st.full;

  bls_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_entry),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_st)
  );

  // line state, error term and the output register
  bls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_st.valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_o       (last_o),
    .status_o     (back_st)
  );

`ifndef SYNTHESIS
  // the back end never pops an empty queue
  a_pop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.pop |-> q_st.valid)
    else $error("pop from empty queue");

  // emitting the final pixel ends the line
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.emit && back_st.emit_last |=> !back_st.active)
    else $error("line still active after last pixel");

  // a pixel is only produced while a line is in progress
  a_emit_when_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.emit |-> back_st.active && back_st.pop)
    else $error("pixel emitted while idle");

  // a new pixel never overwrites one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !back_st.emit)
    else $error("pending pixel overwritten");
`endif

endmodule
